@@ rtl/core/pfcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfcd_pkg: shared types and constants of the parallel flash command device
// Geometry, command bytes, microcode word layout and inter-module structs.
// ----------------------------------------------------------------------------
package pfcd_pkg;

  // Array geometry
  localparam int unsigned BANK_BYTES   = 65536;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned BANK_COUNT   = 2;
  localparam int unsigned ARRAY_BYTES  = BANK_COUNT * BANK_BYTES;
  localparam int unsigned ARR_AW       = $clog2(ARRAY_BYTES);
  localparam int unsigned OFF_AW       = $clog2(BANK_BYTES);

  // Unlock / command addresses and bytes
  localparam logic [15:0] ADDR_A     = 16'h5555;
  localparam logic [15:0] ADDR_B     = 16'h2AAA;
  localparam logic [7:0]  D_UNLOCK1  = 8'hAA;
  localparam logic [7:0]  D_UNLOCK2  = 8'h55;
  localparam logic [7:0]  CMD_ID     = 8'h90;
  localparam logic [7:0]  CMD_EXIT   = 8'hF0;
  localparam logic [7:0]  CMD_ERASE  = 8'h80;
  localparam logic [7:0]  CMD_CHIP   = 8'h10;
  localparam logic [7:0]  CMD_SECTOR = 8'h30;
  localparam logic [7:0]  CMD_PROG   = 8'hA0;
  localparam logic [7:0]  CMD_BANK   = 8'hB0;

  // Configuration register indexes (paddr[3:2])
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MFR_ID    = 2'd0;
  localparam reg_idx_t REG_DEV_ID    = 2'd1;
  localparam reg_idx_t REG_TWO_BANKS = 2'd2;

  // Microcode step addresses
  typedef logic [2:0] upc_t;
  localparam upc_t U_FETCH  = 3'd0;
  localparam upc_t U_DECODE = 3'd1;
  localparam upc_t U_WDISP  = 3'd2;
  localparam upc_t U_PROG   = 3'd3;
  localparam upc_t U_CMD    = 3'd4;
  localparam upc_t U_SWEEP  = 3'd5;
  localparam upc_t U_SWEND  = 3'd6;
  localparam upc_t U_OUTPUT = 3'd7;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_ALWAYS     = 3'd0,
    C_NO_IN      = 3'd1,
    C_READ       = 3'd2,
    C_NOT_PROG   = 3'd3,
    C_NO_ERASE   = 3'd4,
    C_SWEEP_MORE = 3'd5,
    C_INIT       = 3'd6,
    C_OUT_BUSY   = 3'd7
  } cond_e;

  // One control word
  typedef struct packed {
    logic  accept;
    logic  mem_rd;
    logic  prog_wr;
    logic  state_upd;
    logic  sweep_ld;
    logic  sweep_wr;
    logic  clr_init;
    logic  out_ld;
    cond_e cond;
    upc_t  target;
  } ctl_t;

  // Status flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_read;
    logic is_prog;
    logic is_erase;
    logic sweep_more;
    logic out_busy;
  } flags_t;

  // Command decode results
  typedef struct packed {
    logic is_prog;
    logic chip;
    logic sector;
    logic ident;
    logic bank_now;
  } dec_t;

  // Configuration registers
  typedef struct packed {
    logic [7:0] mfr_id;
    logic [7:0] dev_id;
    logic       two_banks;
  } cfg_t;

  // Array strobes
  typedef struct packed {
    logic rd;
    logic prog_wr;
    logic sweep_ld;
    logic sweep_wr;
    logic chip;
    logic sector;
  } arr_ctl_t;

endpackage

@@ rtl/core/pfcd_useq.sv @@
// ----------------------------------------------------------------------------
// pfcd_useq: microcode sequencer
// Control ROM, step counter and conditional jump logic.
// ----------------------------------------------------------------------------
module pfcd_useq import pfcd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctl_t   ctl_o
);

  // Control program
  function automatic ctl_t rom(upc_t a);
    ctl_t w;
    w = '0;
    unique case (a)
      U_FETCH: begin
        w.accept = 1'b1; w.cond = C_NO_IN; w.target = U_FETCH;
      end
      U_DECODE: begin
        w.mem_rd = 1'b1; w.cond = C_READ; w.target = U_OUTPUT;
      end
      U_WDISP: begin
        w.cond = C_NOT_PROG; w.target = U_CMD;
      end
      U_PROG: begin
        w.prog_wr = 1'b1; w.state_upd = 1'b1; w.cond = C_ALWAYS; w.target = U_OUTPUT;
      end
      U_CMD: begin
        w.state_upd = 1'b1; w.sweep_ld = 1'b1; w.cond = C_NO_ERASE; w.target = U_OUTPUT;
      end
      U_SWEEP: begin
        w.sweep_wr = 1'b1; w.cond = C_SWEEP_MORE; w.target = U_SWEEP;
      end
      U_SWEND: begin
        w.clr_init = 1'b1; w.cond = C_INIT; w.target = U_FETCH;
      end
      U_OUTPUT: begin
        w.out_ld = 1'b1; w.cond = C_OUT_BUSY; w.target = U_OUTPUT;
      end
    endcase
    return w;
  endfunction

  upc_t pc_q, pc_d;
  logic init_q, init_d;
  logic take;

  assign ctl_o = rom(pc_q);

  // Condition select and next step
  always_comb begin
    unique case (ctl_o.cond)
      C_ALWAYS:     take = 1'b1;
      C_NO_IN:      take = !flags_i.in_valid;
      C_READ:       take = flags_i.is_read;
      C_NOT_PROG:   take = !flags_i.is_prog;
      C_NO_ERASE:   take = !flags_i.is_erase;
      C_SWEEP_MORE: take = flags_i.sweep_more;
      C_INIT:       take = init_q;
      C_OUT_BUSY:   take = flags_i.out_busy;
    endcase
    pc_d   = take ? ctl_o.target : pc_q + 3'd1;
    init_d = ctl_o.clr_init ? 1'b0 : init_q;
  end

  // Start in the clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= U_SWEEP;
      init_q <= 1'b1;
    end else begin
      pc_q   <= pc_d;
      init_q <= init_d;
    end
  end

  // Clearing pass runs only the sweep steps
  a_init_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (pc_q == U_SWEEP || pc_q == U_SWEND))
    else $error("clearing pass left the sweep steps");

  // Finished sweep proceeds to its end step
  a_sweep_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == U_SWEEP && !flags_i.sweep_more) |=> (pc_q == U_SWEND))
    else $error("sweep did not terminate");

  // One item in flight: no back-to-back accepts
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.accept && flags_i.in_valid) |=> !ctl_o.accept)
    else $error("second transaction accepted while busy");

endmodule

@@ rtl/core/pfcd_cmd.sv @@
// ----------------------------------------------------------------------------
// pfcd_cmd: command decoder
// Unlock sequence tracking, armed commands, ID mode and bank selection.
// ----------------------------------------------------------------------------
module pfcd_cmd import pfcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic        upd_i,
  output dec_t        dec_o
);

  typedef enum logic [5:0] {
    PH_IDLE        = 6'b000001,
    PH_GOT_AA      = 6'b000010,
    PH_CMD         = 6'b000100,
    PH_ERASE_ARMED = 6'b001000,
    PH_ERASE_AA    = 6'b010000,
    PH_ERASE_CMD   = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ARM_NONE = 3'b001,
    ARM_PROG = 3'b010,
    ARM_BANK = 3'b100
  } arm_e;

  phase_e phase_q, phase_d;
  arm_e   arm_q, arm_d;
  logic   ident_q, ident_d;
  logic   bank_q, bank_d;
  logic   sbok, at_a, at_b;
  logic   prog, chip, sector;

  assign sbok = cfg_i.two_banks && (BANK_COUNT > 1);
  assign at_a = (addr_i == ADDR_A);
  assign at_b = (addr_i == ADDR_B);

  // Next state for a write transaction
  always_comb begin
    phase_d = phase_q;
    arm_d   = arm_q;
    ident_d = ident_q;
    bank_d  = bank_q;
    prog    = 1'b0;
    chip    = 1'b0;
    sector  = 1'b0;
    priority if (at_a && data_i == CMD_EXIT) begin
      // abort from anywhere
      phase_d = PH_IDLE;
      arm_d   = ARM_NONE;
      ident_d = 1'b0;
    end else if (arm_q == ARM_PROG) begin
      prog    = 1'b1;
      phase_d = PH_IDLE;
      arm_d   = ARM_NONE;
    end else if (arm_q == ARM_BANK) begin
      if (addr_i == 16'd0 && sbok) bank_d = data_i[0];
      phase_d = PH_IDLE;
      arm_d   = ARM_NONE;
    end else begin
      // stray writes fall back to idle
      phase_d = PH_IDLE;
      arm_d   = ARM_NONE;
      unique case (phase_q)
        PH_IDLE: begin
          if (at_a && data_i == D_UNLOCK1) phase_d = PH_GOT_AA;
        end
        PH_ERASE_ARMED: begin
          if (at_a && data_i == D_UNLOCK1) phase_d = PH_ERASE_AA;
        end
        PH_GOT_AA: begin
          if (at_b && data_i == D_UNLOCK2) phase_d = PH_CMD;
        end
        PH_ERASE_AA: begin
          if (at_b && data_i == D_UNLOCK2) phase_d = PH_ERASE_CMD;
        end
        PH_CMD: begin
          if (at_a) begin
            if (data_i == CMD_ID) ident_d = 1'b1;
            else if (data_i == CMD_ERASE) phase_d = PH_ERASE_ARMED;
            else if (data_i == CMD_PROG) arm_d = ARM_PROG;
            else if (data_i == CMD_BANK && sbok) arm_d = ARM_BANK;
          end
        end
        PH_ERASE_CMD: begin
          if (at_a && data_i == CMD_CHIP) chip = 1'b1;
          else if (data_i == CMD_SECTOR) sector = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      arm_q   <= ARM_NONE;
      ident_q <= 1'b0;
      bank_q  <= 1'b0;
    end else if (upd_i) begin
      phase_q <= phase_d;
      arm_q   <= arm_d;
      ident_q <= ident_d;
      bank_q  <= bank_d;
    end
  end

  assign dec_o.is_prog  = prog;
  assign dec_o.chip     = chip;
  assign dec_o.sector   = sector;
  assign dec_o.ident    = ident_q;
  assign dec_o.bank_now = sbok && bank_q;

endmodule

@@ rtl/core/pfcd_array.sv @@
// ----------------------------------------------------------------------------
// pfcd_array: flash cell array
// Single-port byte memory with registered read and an erase sweep counter.
// ----------------------------------------------------------------------------
module pfcd_array import pfcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arr_ctl_t          ctl_i,
  input  logic [ARR_AW-1:0] addr_i,
  input  logic [7:0]        data_i,
  output logic [7:0]        rdata_o,
  output logic              sweep_more_o
);

  localparam logic [ARR_AW-1:0] LAST_ADDR = ARR_AW'(ARRAY_BYTES - 1);
  localparam logic [ARR_AW-1:0] SEC_MASK  = ARR_AW'(SECTOR_BYTES - 1);

  logic [7:0]        mem [ARRAY_BYTES];
  logic [7:0]        rdata_q;
  logic [ARR_AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [ARR_AW-1:0] sweep_last_q, sweep_last_d;

  // Memory port: erase fill or program AND, plus registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.sweep_wr) mem[sweep_addr_q] <= 8'hFF;
    else if (ctl_i.prog_wr) mem[addr_i] <= rdata_q & data_i;
    if (ctl_i.rd) rdata_q <= mem[addr_i];
  end

  // Sweep range
  always_comb begin
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    if (ctl_i.sweep_ld) begin
      if (ctl_i.chip) begin
        sweep_addr_d = '0;
        sweep_last_d = LAST_ADDR;
      end else begin
        sweep_addr_d = addr_i & ~SEC_MASK;
        sweep_last_d = addr_i | SEC_MASK;
      end
    end else if (ctl_i.sweep_wr) begin
      sweep_addr_d = sweep_addr_q + 1'b1;
    end
  end

  // Reset loads a whole-array sweep for the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
      sweep_last_q <= LAST_ADDR;
    end else begin
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
    end
  end

  assign rdata_o      = rdata_q;
  assign sweep_more_o = (sweep_addr_q != sweep_last_q);

  // Sweep and program never share the write port
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.sweep_wr |-> !ctl_i.prog_wr)
    else $error("sweep and program write together");

  // Sector sweep spans exactly one sector
  a_sec_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.sweep_ld && ctl_i.sector && !ctl_i.chip)
      |=> (sweep_last_q - sweep_addr_q) == SEC_MASK)
    else $error("sector sweep range wrong");

endmodule

@@ rtl/core/parallel_flash_command_device_unit.sv @@
// ----------------------------------------------------------------------------
// parallel_flash_command_device_unit: 8-bit parallel flash command device
// Bus read/write transactions in, one result per transaction out.
// ----------------------------------------------------------------------------
// A read is accepted, reads the array in decode and loads the output
// register in its output step; a write runs decode, dispatch and the
// program or command step; an erase adds a sweep of a sector or the chip
// and one end step. One transaction is in flight; the next is accepted
// once the result is loaded. After reset a clearing pass fills the array
// with 0xFF, s_tready low meanwhile; APB writes are taken throughout.
// ----------------------------------------------------------------------------
module parallel_flash_command_device_unit import pfcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input: address [15:0], write_data [23:16]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  // input: func [0]
  input  logic        s_tuser,
  // output: read_data [7:0], id_mode [8], bank_now [9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctl_t              ctl;
  flags_t            flags;
  dec_t              dec;
  cfg_t              cfg_q;
  arr_ctl_t          arr_ctl;
  reg_idx_t          reg_idx;
  logic              func_q;
  logic [15:0]       addr_q;
  logic [7:0]        wdata_q;
  logic [ARR_AW-1:0] mem_addr;
  logic [7:0]        arr_rdata;
  logic              sweep_more;
  logic              out_busy, out_take;
  logic              m_tvalid_q;
  logic [15:0]       m_tdata_q;
  logic [7:0]        rd_byte;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mfr_id    <= 8'd194;
      cfg_q.dev_id    <= 8'd28;
      cfg_q.two_banks <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MFR_ID:    cfg_q.mfr_id    <= pwdata[7:0];
        REG_DEV_ID:    cfg_q.dev_id    <= pwdata[7:0];
        REG_TWO_BANKS: cfg_q.two_banks <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MFR_ID:    prdata = {24'd0, cfg_q.mfr_id};
      REG_DEV_ID:    prdata = {24'd0, cfg_q.dev_id};
      REG_TWO_BANKS: prdata = {31'd0, cfg_q.two_banks};
      default:       prdata = 32'd0;
    endcase
  end

  // Input transaction capture
  assign s_tready = ctl.accept;

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      func_q  <= s_tuser;
      addr_q  <= s_tdata[15:0];
      wdata_q <= s_tdata[23:16];
    end
  end

  // Sequencer
  assign flags.in_valid   = s_tvalid;
  assign flags.is_read    = !func_q;
  assign flags.is_prog    = dec.is_prog;
  assign flags.is_erase   = dec.chip || dec.sector;
  assign flags.sweep_more = sweep_more;
  assign flags.out_busy   = out_busy;

  pfcd_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  pfcd_cmd u_cmd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .addr_i (addr_q),
    .data_i (wdata_q),
    .upd_i  (ctl.state_upd),
    .dec_o  (dec)
  );

  // Array address: bank base plus offset within bank
  assign mem_addr = ARR_AW'(addr_q[OFF_AW-1:0])
                  + (dec.bank_now ? ARR_AW'(BANK_BYTES) : '0);

  assign arr_ctl.rd       = ctl.mem_rd;
  assign arr_ctl.prog_wr  = ctl.prog_wr;
  assign arr_ctl.sweep_ld = ctl.sweep_ld && (dec.chip || dec.sector);
  assign arr_ctl.sweep_wr = ctl.sweep_wr;
  assign arr_ctl.chip     = dec.chip;
  assign arr_ctl.sector   = dec.sector;

  pfcd_array u_array (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (arr_ctl),
    .addr_i       (mem_addr),
    .data_i       (wdata_q),
    .rdata_o      (arr_rdata),
    .sweep_more_o (sweep_more)
  );

  // Read data select
  always_comb begin
    if (func_q) rd_byte = 8'h00;
    else if (dec.ident && addr_q == 16'd0) rd_byte = cfg_q.mfr_id;
    else if (dec.ident && addr_q == 16'd1) rd_byte = cfg_q.dev_id;
    else rd_byte = arr_rdata;
  end

  // Output register
  assign out_busy = m_tvalid_q && !m_tready;
  assign out_take = ctl.out_ld && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_tvalid_q <= 1'b0;
    else if (out_take) m_tvalid_q <= 1'b1;
    else if (m_tready) m_tvalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_take) m_tdata_q <= {6'd0, dec.bank_now, dec.ident, rd_byte};
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

endmodule
